FILE: rtl/klvls_pkg.sv
// klvls_pkg: types, phase and stop codes and default sizes for the klv local-set parser
// depends on nothing; used by klvls_parse, klv_local_set_parser_core and the bench
`timescale 1ns / 1ps
`default_nettype none

package klvls_pkg;

  // default sizes, handed to the top level parameters
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int MAX_BER_BYTES_DEF = 4;

  // ber length byte layout
  localparam int BER_LONG_BIT = 7;
  localparam logic [6:0] BER_COUNT_MASK = 7'h7F;

  // a tag needs at least this many bytes left, tag byte included
  localparam int MIN_TAG_BYTES = 4;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN_FIRST,
    PH_LEN_MORE,
    PH_VALUE,
    PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {
    STOP_NONE,
    STOP_SHORT_TAG,
    STOP_BER_LONG,
    STOP_OVERRUN
  } stop_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [7:0]  value_byte;
    logic        value_valid;
    logic [15:0] value_index;
    logic [15:0] value_length;
    logic        first_of_value;
    logic        last_of_value;
    logic        empty_value;
    logic        packet_done;
    logic [15:0] leftover_bytes;
    logic [1:0]  stop_reason;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/klvls_stream_if.sv
// klvls_stream_if: valid/ready channel carrying one payload struct per request
// payload type is a parameter; types come from klvls_pkg at the instance
`timescale 1ns / 1ps
`default_nettype none

interface klvls_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/klvls_stage.sv
// klvls_stage: one pipeline register on a valid/ready channel
// depends on klvls_stream_if
`timescale 1ns / 1ps
`default_nettype none

module klvls_stage (
  input  wire logic    clk,
  input  wire logic    rst,
  klvls_stream_if.sink   up,
  klvls_stream_if.source down
);
  logic full;

  // takes a new request when empty or when the held one leaves in the same cycle
  assign up.ready   = !full || down.ready;
  assign down.valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (up.ready) begin
      full <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      down.payload <= up.payload;
    end
  end
endmodule

`default_nettype wire

FILE: rtl/klvls_parse.sv
// klvls_parse: parser state registers and the per-byte next-state and result logic
// depends on klvls_pkg and klvls_stream_if
`timescale 1ns / 1ps
`default_nettype none

module klvls_parse #(
  parameter int LENGTH_BITS   = klvls_pkg::LENGTH_BITS_DEF,
  parameter int MAX_BER_BYTES = klvls_pkg::MAX_BER_BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  klvls_stream_if.sink   staged,
  klvls_stream_if.source res
);
  import klvls_pkg::*;

  localparam int LB    = LENGTH_BITS;
  localparam int ACC_W = 8 * MAX_BER_BYTES;
  localparam int CMP_W = (ACC_W > LB) ? ACC_W : LB;

  phase_t           phase, phase_next;
  logic [LB-1:0]    remaining, remaining_next;
  logic [7:0]       cur_tag, cur_tag_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic [2:0]       len_left, len_left_next;
  logic [LB-1:0]    vpos, vpos_next;
  stop_t            stop, stop_next;
  logic [LB-1:0]    held, held_next;
  logic [LB-1:0]    trip, trip_next;

  in_item_t   item;
  out_item_t  result;
  logic       emit;
  logic       step;
  logic       len_check;
  logic [LB-1:0] after;
  logic [6:0] ber_count;

  assign item          = staged.payload;
  assign step          = staged.valid && res.ready;
  assign staged.ready  = res.ready;
  assign res.valid     = staged.valid && emit;
  assign res.payload   = result;
  assign ber_count     = item.data_byte[6:0] & BER_COUNT_MASK;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    cur_tag_next   = cur_tag;
    acc_next       = acc;
    len_left_next  = len_left;
    vpos_next      = vpos;
    stop_next      = stop;
    held_next      = held;
    trip_next      = trip;
    result         = '0;
    emit           = 1'b0;
    len_check      = 1'b0;
    after          = '0;

    // first byte restarts the packet, even one still open
    if (item.first_byte) begin
      remaining_next = LB'(item.packet_length);
      phase_next     = PH_TAG;
      stop_next      = STOP_NONE;
      held_next      = '0;
      acc_next       = '0;
      len_left_next  = '0;
      vpos_next      = '0;
      trip_next      = '0;
    end

    if (remaining_next != '0) begin
      after          = remaining_next - LB'(1);
      remaining_next = after;

      unique case (phase_next)
        PH_TAG: begin
          if (CMP_W'(remaining_next) + CMP_W'(1) < CMP_W'(MIN_TAG_BYTES)) begin
            stop_next  = STOP_SHORT_TAG;
            held_next  = after + LB'(1);
            phase_next = PH_STOPPED;
          end else begin
            cur_tag_next = item.data_byte;
            trip_next    = after + LB'(1);
            phase_next   = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          if (!item.data_byte[BER_LONG_BIT]) begin
            acc_next  = ACC_W'(item.data_byte);
            len_check = 1'b1;
          end else if (32'(ber_count) > 32'(MAX_BER_BYTES)) begin
            stop_next  = STOP_BER_LONG;
            held_next  = trip_next;
            phase_next = PH_STOPPED;
          end else if (LB'(ber_count) > after) begin
            stop_next  = STOP_OVERRUN;
            held_next  = trip_next;
            phase_next = PH_STOPPED;
          end else if (ber_count == '0) begin
            acc_next  = '0;
            len_check = 1'b1;
          end else begin
            acc_next      = '0;
            len_left_next = ber_count[2:0];
            phase_next    = PH_LEN_MORE;
          end
        end
        PH_LEN_MORE: begin
          acc_next = ACC_W'({acc_next, item.data_byte});
          if (len_left_next != '0) begin
            len_left_next = len_left_next - 3'd1;
          end
          len_check = (len_left_next == '0);
        end
        PH_VALUE: begin
          result.tag            = cur_tag_next;
          result.value_byte     = item.data_byte;
          result.value_valid    = 1'b1;
          result.value_index    = 16'(vpos_next);
          result.value_length   = 16'(acc_next);
          result.first_of_value = (vpos_next == '0);
          vpos_next             = vpos_next + LB'(1);
          if (CMP_W'(vpos_next) >= CMP_W'(acc_next)) begin
            result.last_of_value = 1'b1;
            phase_next           = PH_TAG;
          end
          emit = 1'b1;
        end
        default: begin
          phase_next = PH_STOPPED;
        end
      endcase

      // length fully decoded: check it fits, then empty triplet or value bytes
      if (len_check) begin
        if (CMP_W'(acc_next) > CMP_W'(after)) begin
          stop_next  = STOP_OVERRUN;
          held_next  = trip_next;
          phase_next = PH_STOPPED;
        end else if (acc_next == '0) begin
          result.tag           = cur_tag_next;
          result.last_of_value = 1'b1;
          result.empty_value   = 1'b1;
          phase_next           = PH_TAG;
          emit                 = 1'b1;
        end else begin
          vpos_next  = '0;
          phase_next = PH_VALUE;
        end
      end

      // final byte of the packet
      if (after == '0) begin
        result.packet_done = 1'b1;
        if (phase_next == PH_STOPPED) begin
          result.leftover_bytes = 16'(held_next);
          result.stop_reason    = stop_next;
        end
        phase_next = PH_TAG;
        emit       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TAG;
      remaining <= '0;
      cur_tag   <= '0;
      acc       <= '0;
      len_left  <= '0;
      vpos      <= '0;
      stop      <= STOP_NONE;
      held      <= '0;
      trip      <= '0;
    end else if (step) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      cur_tag   <= cur_tag_next;
      acc       <= acc_next;
      len_left  <= len_left_next;
      vpos      <= vpos_next;
      stop      <= stop_next;
      held      <= held_next;
      trip      <= trip_next;
    end
  end
endmodule

`default_nettype wire

FILE: rtl/klv_local_set_parser_core.sv
// klv_local_set_parser_core: top level of the klv local-set triplet parser
// depends on klvls_pkg, klvls_stream_if, klvls_stage and klvls_parse
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                      request
// bytes     in   klvls_pkg::in_item_t         one byte of a packet value field
// results   out  klvls_pkg::out_item_t        one value byte, empty mark or packet end
//
// one byte per cycle sustained while results is not stalled; a byte is taken
// into the input register, parsed from there and its result (if any) is written
// to the output register, so results.valid comes from the output register;
// the parse state is updated once per accepted byte, which sets the rate
// rst (synchronous) empties both registers and returns the parser to the tag
// phase with no packet open
// a stall on results backs up through the output register into the input
// register; bytes that give no result still wait for a free output slot

module klv_local_set_parser_core #(
  parameter int LENGTH_BITS   = klvls_pkg::LENGTH_BITS_DEF,
  parameter int MAX_BER_BYTES = klvls_pkg::MAX_BER_BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  klvls_stream_if.sink   bytes,
  klvls_stream_if.source results
);
  import klvls_pkg::*;

  // input register to parser
  klvls_stream_if #(.T(in_item_t))  staged ();
  // parser to output register
  klvls_stream_if #(.T(out_item_t)) parsed ();

  klvls_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .up   (bytes),
    .down (staged)
  );

  // phase machine: tag, first length byte, long length bytes, value, stopped
  klvls_parse #(
    .LENGTH_BITS   (LENGTH_BITS),
    .MAX_BER_BYTES (MAX_BER_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .staged (staged),
    .res    (parsed)
  );

  klvls_stage u_out_stage (
    .clk  (clk),
    .rst  (rst),
    .up   (parsed),
    .down (results)
  );
endmodule

`default_nettype wire

FILE: dv/klv_local_set_parser_core_tb.sv
// klv_local_set_parser_core_tb: self-checking bench for the klv local-set triplet parser
// depends on klvls_pkg, klvls_stream_if and klv_local_set_parser_core from rtl
// byte requests are predicted on acceptance and results are checked in order
`timescale 1ns / 1ps

module klv_local_set_parser_core_tb;
  import klvls_pkg::*;

  // one queued byte request; drain makes the driver wait until all results are back
  typedef struct {
    in_item_t item;
    bit       drain;
  } queued_byte_t;

  logic clk;
  logic rst;

  klvls_stream_if #(.T(in_item_t))  byte_ch ();
  klvls_stream_if #(.T(out_item_t)) result_ch ();

  klv_local_set_parser_core dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (result_ch)
  );

  always #4 clk = ~clk;

  queued_byte_t pending_bytes[$];
  out_item_t    expected_results[$];
  int           bytes_accepted;
  int           results_seen;
  int           mismatches;
  int           total_bytes;

  // ---------------------------------------------------------------------------
  // parser state as the bench sees it
  // ---------------------------------------------------------------------------
  phase_t      parse_ph;
  logic [15:0] bytes_left;
  logic [7:0]  cur_tag;
  logic [31:0] len_acc;
  logic [2:0]  len_bytes_left;
  logic [15:0] val_pos;
  stop_t       stop_code;
  logic [15:0] leftover_held;
  logic [15:0] triplet_start;

  // parsing stops for the rest of the packet; the final byte reports it
  function automatic void halt_parse(input stop_t why, input logic [15:0] leftover);
    stop_code     = why;
    leftover_held = leftover;
    parse_ph      = PH_STOPPED;
  endfunction

  // the length is complete; either it overruns, it is an empty triplet, or
  // the value bytes follow
  function automatic bit length_complete(input logic [15:0] left_after,
                                         inout out_item_t res);
    if (len_acc > {16'd0, left_after}) begin
      halt_parse(STOP_OVERRUN, triplet_start);
      return 1'b0;
    end
    if (len_acc == 32'd0) begin
      res.tag           = cur_tag;
      res.last_of_value = 1'b1;
      res.empty_value   = 1'b1;
      parse_ph          = PH_TAG;
      return 1'b1;
    end
    val_pos  = 16'd0;
    parse_ph = PH_VALUE;
    return 1'b0;
  endfunction

  // predicted effect of one accepted byte; returns 1 when it gives a result
  function automatic bit parse_byte(input in_item_t b, output out_item_t res);
    logic [15:0] r;
    logic [15:0] left_after;
    logic [6:0]  ber_count;
    bit          emit;
    emit = 1'b0;
    res  = '0;
    if (b.first_byte) begin
      // a new packet, possibly abandoning the open one
      bytes_left     = b.packet_length;
      parse_ph       = PH_TAG;
      stop_code      = STOP_NONE;
      leftover_held  = 16'd0;
      len_acc        = 32'd0;
      len_bytes_left = 3'd0;
      val_pos        = 16'd0;
      triplet_start  = 16'd0;
    end
    // stray byte between packets, or zero-length packet
    if (bytes_left == 16'd0) return 1'b0;

    r          = bytes_left;
    left_after = r - 16'd1;
    bytes_left = left_after;

    case (parse_ph)
      PH_TAG: begin
        if (r < MIN_TAG_BYTES) begin
          halt_parse(STOP_SHORT_TAG, r);
        end else begin
          cur_tag       = b.data_byte;
          triplet_start = r;
          parse_ph      = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        if (!b.data_byte[BER_LONG_BIT]) begin
          len_acc = {24'd0, b.data_byte};
          emit    = length_complete(left_after, res);
        end else begin
          ber_count = b.data_byte[6:0] & BER_COUNT_MASK;
          if (ber_count > MAX_BER_BYTES_DEF) begin
            halt_parse(STOP_BER_LONG, triplet_start);
          end else if ({9'd0, ber_count} > left_after) begin
            // length bytes would run past the packet end
            halt_parse(STOP_OVERRUN, triplet_start);
          end else if (ber_count == 7'd0) begin
            // bare long form means length zero
            len_acc = 32'd0;
            emit    = length_complete(left_after, res);
          end else begin
            len_acc        = 32'd0;
            len_bytes_left = ber_count[2:0];
            parse_ph       = PH_LEN_MORE;
          end
        end
      end
      PH_LEN_MORE: begin
        len_acc = {len_acc[23:0], b.data_byte};
        if (len_bytes_left != 3'd0) len_bytes_left = len_bytes_left - 3'd1;
        if (len_bytes_left == 3'd0) emit = length_complete(left_after, res);
      end
      PH_VALUE: begin
        res.tag            = cur_tag;
        res.value_byte     = b.data_byte;
        res.value_valid    = 1'b1;
        res.value_index    = val_pos;
        res.value_length   = len_acc[15:0];
        res.first_of_value = (val_pos == 16'd0);
        val_pos            = val_pos + 16'd1;
        if ({16'd0, val_pos} >= len_acc) begin
          res.last_of_value = 1'b1;
          parse_ph          = PH_TAG;
        end
        emit = 1'b1;
      end
      default: parse_ph = PH_STOPPED;
    endcase

    // final byte of the packet; may share the result with a value byte or
    // an empty triplet
    if (left_after == 16'd0) begin
      res.packet_done = 1'b1;
      if (parse_ph == PH_STOPPED) begin
        res.leftover_bytes = leftover_held;
        res.stop_reason    = stop_code;
      end
      parse_ph = PH_TAG;
      emit     = 1'b1;
    end
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                results_seen, name, got, want));
  endtask

  task automatic compare_result(input out_item_t got, input out_item_t want);
    check_field("tag",            16'(got.tag),            16'(want.tag));
    check_field("value_byte",     16'(got.value_byte),     16'(want.value_byte));
    check_field("value_valid",    16'(got.value_valid),    16'(want.value_valid));
    check_field("value_index",    got.value_index,         want.value_index);
    check_field("value_length",   got.value_length,        want.value_length);
    check_field("first_of_value", 16'(got.first_of_value), 16'(want.first_of_value));
    check_field("last_of_value",  16'(got.last_of_value),  16'(want.last_of_value));
    check_field("empty_value",    16'(got.empty_value),    16'(want.empty_value));
    check_field("packet_done",    16'(got.packet_done),    16'(want.packet_done));
    check_field("leftover_bytes", got.leftover_bytes,      want.leftover_bytes);
    check_field("stop_reason",    16'(got.stop_reason),    16'(want.stop_reason));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] d, input bit first,
                           input logic [15:0] plen, input bit drain);
    queued_byte_t q;
    q.item.data_byte     = d;
    q.item.first_byte    = first;
    q.item.packet_length = plen;
    q.drain              = drain;
    pending_bytes        = {pending_bytes, q};
  endtask

  // first byte carries the packet length; the rest carry random noise there
  task automatic add_packet(input logic [7:0] body[$], input logic [15:0] plen,
                            input bit drain);
    foreach (body[i])
      push_byte(body[i], i == 0, (i == 0) ? plen : 16'($urandom), (i == 0) && drain);
  endtask

  // mostly well-formed triplets with random content, some broken on purpose
  task automatic add_random_packet(input bit drain);
    logic [7:0]  body[$];
    logic [15:0] plen;
    int          n_trip;
    int          vlen;
    int          nb;
    int          pick;
    n_trip = $urandom_range(1, 4);
    for (int t = 0; t < n_trip; t++) begin
      pick = $urandom_range(99);
      if (pick < 15)      vlen = 0;
      else if (pick < 85) vlen = $urandom_range(1, 8);
      else if (pick < 95) vlen = $urandom_range(9, 140);
      else                vlen = $urandom_range(141, 300);
      body = {body, 8'($urandom)};
      if (vlen == 0 && $urandom_range(3) == 0) begin
        body = {body, 8'h80};
      end else if (vlen < 128 && $urandom_range(3) != 0) begin
        body = {body, 8'(vlen)};
      end else begin
        // long form, padded with leading zero bytes at random
        nb = (vlen > 255) ? 2 : 1;
        nb = nb + $urandom_range(0, MAX_BER_BYTES_DEF - nb);
        body = {body, 8'h80 | 8'(nb)};
        for (int k = nb - 1; k >= 0; k--) body = {body, 8'(vlen >> (8 * k))};
      end
      for (int k = 0; k < vlen; k++) body = {body, 8'($urandom)};
    end
    plen = 16'(body.size());
    pick = $urandom_range(99);
    if (pick < 70) begin
      // clean packet
    end else if (pick < 76) begin
      // a short tail that cannot hold a triplet
      repeat ($urandom_range(1, 3)) body = {body, 8'($urandom)};
      plen = 16'(body.size());
    end else if (pick < 82) begin
      // declared length falls short of the triplets
      plen = 16'($urandom_range(1, body.size()));
      while (body.size() > plen) void'(body.pop_back());
    end else if (pick < 88) begin
      // ber form longer than allowed
      body = {body, 8'($urandom)};
      body = {body, 8'h80 | 8'($urandom_range(MAX_BER_BYTES_DEF + 1, 127))};
      repeat ($urandom_range(2, 5)) body = {body, 8'($urandom)};
      plen = 16'(body.size());
    end else if (pick < 94) begin
      // declared length longer than sent; the next packet restarts the parser
      plen = 16'($urandom_range(body.size() + 1, 65535));
    end else begin
      // pure noise
      foreach (body[i]) body[i] = 8'($urandom);
    end
    add_packet(body, plen, drain);
    total_bytes += body.size();
    // occasional bytes between packets
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 16'($urandom), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // driver: feeds byte requests from the pending queue, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    out_item_t    res;
    queued_byte_t nxt;
    bit           idle;
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (parse_byte(byte_ch.payload, res)) expected_results = {expected_results, res};
        bytes_accepted++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        // no idling for a stretch in the middle of the run
        idle = (bytes_accepted < 400 || bytes_accepted >= 650) &&
               ($urandom_range(99) < 17);
        if (pending_bytes.size() != 0 && !idle &&
            !(pending_bytes[0].drain && expected_results.size() != 0)) begin
          nxt = pending_bytes[0];
          pending_bytes.delete(0);
          byte_ch.payload <= nxt.item;
          byte_ch.valid   <= 1'b1;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes results with random stalls and checks them in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    out_item_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, tag %0h value %0h done %0b",
                                    result_ch.payload.tag, result_ch.payload.value_byte,
                                    result_ch.payload.packet_done));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          compare_result(result_ch.payload, want);
        end
      end
      result_ch.ready <= (results_seen >= 300 && results_seen < 450) ||
                         ($urandom_range(99) >= 17);
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.payload   = '0;
    result_ch.ready   = 1'b0;
    bytes_accepted    = 0;
    results_seen      = 0;
    mismatches        = 0;
    total_bytes       = 0;

    // parser state after reset
    parse_ph       = PH_TAG;
    bytes_left     = 16'd0;
    cur_tag        = 8'd0;
    len_acc        = 32'd0;
    len_bytes_left = 3'd0;
    val_pos        = 16'd0;
    stop_code      = STOP_NONE;
    leftover_held  = 16'd0;
    triplet_start  = 16'd0;

    // directed part
    // stray byte with no packet open
    push_byte(8'hFF, 1'b0, 16'hFFFF, 1'b0);
    // zero packet length opens nothing
    push_byte(8'h00, 1'b1, 16'h0000, 1'b0);
    // two-byte value, bare 0x80 empty triplet, then too few bytes at a tag
    add_packet('{8'h01, 8'h02, 8'hAA, 8'h55, 8'h02, 8'h80, 8'h00, 8'hFF}, 16'd8, 1'b0);
    // long form length, final byte is also the only value byte
    add_packet('{8'h10, 8'h82, 8'h00, 8'h01, 8'h7F}, 16'd5, 1'b0);
    // ber form far too long
    add_packet('{8'h20, 8'hFF, 8'h00, 8'h00}, 16'd4, 1'b0);
    // length bytes past the packet end
    add_packet('{8'h30, 8'h84, 8'h12, 8'h34}, 16'd4, 1'b0);
    // value longer than the packet, then abandoned by a restart
    add_packet('{8'h40, 8'h82, 8'hFF, 8'hFF}, 16'hFFFF, 1'b0);
    // empty triplet completes on the final byte
    add_packet('{8'h60, 8'h83, 8'h00, 8'h00, 8'h00}, 16'd5, 1'b0);

    // random part; the first packet waits for the directed results to drain
    add_random_packet(1'b1);
    while (total_bytes < 1400) add_random_packet($urandom_range(99) < 3);
    total_bytes = pending_bytes.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (bytes_accepted < total_bytes || expected_results.size() != 0)
      @(posedge clk);
    // room for any stray late result to show up
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
